### sv/tti_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the time table interpolator.
package tti_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = 11;
    localparam int INDEX_W     = 10;
    localparam int TIME_W      = 32;
    localparam int VALUE_W     = 32;
    localparam int STATUS_W    = 3;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_LINEAR = 2'd1,
        OP_HOLD   = 2'd2,
        OP_SLOPE  = 2'd3
    } opcode_t;

    localparam logic [STATUS_W-1:0] STS_OK     = 3'd0;
    localparam logic [STATUS_W-1:0] STS_EMPTY  = 3'd1;
    localparam logic [STATUS_W-1:0] STS_BEFORE = 3'd2;
    localparam logic [STATUS_W-1:0] STS_RANGE  = 3'd3;
    localparam logic [STATUS_W-1:0] STS_ZERO   = 3'd4;

endpackage

### sv/time_table_interpolator.sv
`timescale 1ns / 1ps
// Time table interpolator: table memory, scan sequencer and serial divider.
// A load item is taken while idle and writes one point into a table memory
// with one write port and one read port (time and value side by side); it
// gives no result. A query item steps over the table points from the search
// cursor, one point per cycle through the memory read port, and restarts the
// search at point 0 when the cursor does not suit the query. Hold queries and
// empty, before-first-point, zero-segment or out-of-range outcomes use neither
// the multiplier nor the divider. Linear queries that interpolate go on through
// the 32x32 multiply and the 33-step restoring divider; slope queries go straight
// to the divider. Items are worked one at a time; a finished result waits in the
// output register while the next item is taken.
module time_table_interpolator (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [tti_pkg::CNT_W-1:0]         cfg_wr_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [1:0]                        s_opcode,
    input  logic [tti_pkg::INDEX_W-1:0]       s_entry_index,
    input  logic [tti_pkg::TIME_W-1:0]        s_entry_time,
    input  logic signed [tti_pkg::VALUE_W-1:0] s_entry_value,
    input  logic [tti_pkg::TIME_W-1:0]        s_query_time,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [tti_pkg::VALUE_W-1:0] m_result_value,
    output logic [tti_pkg::STATUS_W-1:0]      m_status
);
    import tti_pkg::*;

    localparam int DIV_STEPS = 33;
    localparam int STEP_W    = $clog2(DIV_STEPS);
    localparam int MEM_W     = TIME_W + VALUE_W;

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_FIRST   = 8'b0000_0010,
        S_RD_CUR  = 8'b0000_0100,
        S_RD_NEXT = 8'b0000_1000,
        S_SCAN    = 8'b0001_0000,
        S_MUL     = 8'b0010_0000,
        S_DIV     = 8'b0100_0000,
        S_DONE    = 8'b1000_0000
    } state_t;

    // control
    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [CNT_W-1:0]       cursor_reg, cursor_next;
    logic                   m_valid_reg, m_valid_next;
    // payload
    opcode_t                op_reg, op_next;
    logic [TIME_W-1:0]      qtime_reg, qtime_next;
    logic [CNT_W-1:0]       idx_reg, idx_next;
    logic [TIME_W-1:0]      prev_t_reg, prev_t_next;
    logic signed [VALUE_W-1:0] prev_v_reg, prev_v_next;
    logic [TIME_W-1:0]      cur_t_reg, cur_t_next;
    logic signed [VALUE_W-1:0] cur_v_reg, cur_v_next;
    logic                   neg_reg, neg_next;
    logic [31:0]            mag_reg, mag_next;
    logic [TIME_W-1:0]      a_reg, a_next;
    logic [TIME_W-1:0]      dt_reg, dt_next;
    logic [31:0]            rem_reg, rem_next;
    logic [DIV_STEPS-1:0]   low_reg, low_next;
    logic [STEP_W-1:0]      step_reg, step_next;
    logic signed [VALUE_W-1:0] res_reg, res_next;
    logic [STATUS_W-1:0]    status_reg, status_next;
    logic signed [VALUE_W-1:0] m_result_reg, m_result_next;
    logic [STATUS_W-1:0]    m_status_reg, m_status_next;

    // table memory
    logic [MEM_W-1:0]       tbl_mem [TABLE_DEPTH];
    logic [MEM_W-1:0]       rd_data_reg;
    logic [ADDR_W-1:0]      rd_addr;
    logic                   mem_we;
    logic [ADDR_W-1:0]      wr_addr;

    logic [TIME_W-1:0]      rd_t;
    logic signed [VALUE_W-1:0] rd_v;
    logic [CNT_W-1:0]       n_pts;
    logic [CNT_W:0]         idx_p1, idx_p2;
    logic                   has_next;
    logic signed [32:0]     diff;
    logic [63:0]            prod;
    logic [32:0]            trial, trial_sub;
    logic                   ge;
    logic signed [34:0]     quot_s, lin_sum;

    function automatic logic signed [31:0] sat32(input logic signed [34:0] x);
        logic signed [31:0] r;
        if (x[34:31] == 4'b0000 || x[34:31] == 4'b1111) begin
            r = x[31:0];
        end else if (x[34]) begin
            r = 32'sh8000_0000;
        end else begin
            r = 32'sh7FFF_FFFF;
        end
        return r;
    endfunction

    assign rd_t     = rd_data_reg[MEM_W-1:VALUE_W];
    assign rd_v     = rd_data_reg[VALUE_W-1:0];
    assign n_pts    = (32'(count_reg) > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH) : count_reg;
    assign idx_p1   = {1'b0, idx_reg} + (CNT_W+1)'(1);
    assign idx_p2   = {1'b0, idx_reg} + (CNT_W+1)'(2);
    assign has_next = idx_p1 < {1'b0, n_pts};
    assign diff     = {rd_v[VALUE_W-1], rd_v} - {cur_v_reg[VALUE_W-1], cur_v_reg};
    assign prod     = 64'(mag_reg) * 64'(a_reg);
    assign trial    = {rem_reg, low_reg[DIV_STEPS-1]};
    assign trial_sub = trial - {1'b0, dt_reg};
    assign ge       = trial >= {1'b0, dt_reg};
    assign quot_s   = neg_reg ? -$signed({2'b00, low_reg}) : $signed({2'b00, low_reg});
    assign lin_sum  = quot_s + 35'(cur_v_reg);
    assign wr_addr  = ADDR_W'(s_entry_index);

    assign s_ready        = (state_reg == S_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_result_value = m_result_reg;
    assign m_status       = m_status_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            tbl_mem[wr_addr] <= {s_entry_time, s_entry_value};
        end
        rd_data_reg <= tbl_mem[rd_addr];
    end

    always_comb begin
        state_next    = state_reg;
        count_next    = cfg_wr_en ? cfg_wr_data : count_reg;
        cursor_next   = cursor_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        op_next       = op_reg;
        qtime_next    = qtime_reg;
        idx_next      = idx_reg;
        prev_t_next   = prev_t_reg;
        prev_v_next   = prev_v_reg;
        cur_t_next    = cur_t_reg;
        cur_v_next    = cur_v_reg;
        neg_next      = neg_reg;
        mag_next      = mag_reg;
        a_next        = a_reg;
        dt_next       = dt_reg;
        rem_next      = rem_reg;
        low_next      = low_reg;
        step_next     = step_reg;
        res_next      = res_reg;
        status_next   = status_reg;
        m_result_next = m_result_reg;
        m_status_next = m_status_reg;
        rd_addr       = '0;
        mem_we        = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    if (opcode_t'(s_opcode) == OP_LOAD) begin
                        mem_we = (32'(s_entry_index) < TABLE_DEPTH);
                    end else begin
                        op_next    = opcode_t'(s_opcode);
                        qtime_next = s_query_time;
                        if (n_pts == '0) begin
                            res_next    = '0;
                            status_next = STS_EMPTY;
                            state_next  = S_DONE;
                        end else begin
                            rd_addr    = '0;
                            state_next = S_FIRST;
                        end
                    end
                end
            end
            S_FIRST: begin
                // rd data is point 0
                if (rd_t > qtime_reg) begin
                    res_next    = '0;
                    status_next = STS_BEFORE;
                    state_next  = S_DONE;
                end else begin
                    idx_next   = (cursor_reg >= n_pts) ? '0 : cursor_reg;
                    rd_addr    = ADDR_W'((cursor_reg >= n_pts) ? '0 : cursor_reg) - ADDR_W'(1);
                    state_next = S_RD_CUR;
                end
            end
            S_RD_CUR: begin
                prev_t_next = rd_t;
                prev_v_next = rd_v;
                rd_addr     = ADDR_W'(idx_reg);
                state_next  = S_RD_NEXT;
            end
            S_RD_NEXT: begin
                // cursor restart; never fires once the index is 0
                if ((op_reg == OP_LINEAR && rd_t > qtime_reg) ||
                    (op_reg != OP_LINEAR && idx_reg != '0 && prev_t_reg > qtime_reg)) begin
                    idx_next   = '0;
                    rd_addr    = '1;
                    state_next = S_RD_CUR;
                end else begin
                    cur_t_next = rd_t;
                    cur_v_next = rd_v;
                    rd_addr    = ADDR_W'(idx_p1);
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                // cur = point idx, rd data = point idx+1
                neg_next = diff[32];
                mag_next = diff[32] ? 32'(-diff) : diff[31:0];
                a_next   = qtime_reg - cur_t_reg;
                dt_next  = rd_t - cur_t_reg;
                rem_next = '0;
                low_next = {1'b0, diff[32] ? 32'(-diff) : diff[31:0]};
                step_next = '0;
                if ((op_reg == OP_LINEAR || op_reg == OP_HOLD) && cur_t_reg == qtime_reg) begin
                    cursor_next = idx_reg;
                    res_next    = cur_v_reg;
                    status_next = STS_OK;
                    state_next  = S_DONE;
                end else if (op_reg == OP_HOLD && idx_reg != '0 && qtime_reg < cur_t_reg) begin
                    cursor_next = idx_reg;
                    res_next    = prev_v_reg;
                    status_next = STS_OK;
                    state_next  = S_DONE;
                end else if ((op_reg == OP_LINEAR && has_next && cur_t_reg <= qtime_reg &&
                              rd_t >= qtime_reg) ||
                             (op_reg == OP_SLOPE && has_next &&
                              ((cur_t_reg <= qtime_reg && rd_t > qtime_reg) ||
                               (idx_p2 == {1'b0, n_pts} && rd_t == qtime_reg)))) begin
                    cursor_next = idx_reg;
                    if (rd_t <= cur_t_reg) begin
                        res_next    = '0;
                        status_next = STS_ZERO;
                        state_next  = S_DONE;
                    end else if (op_reg == OP_LINEAR) begin
                        state_next = S_MUL;
                    end else begin
                        state_next = S_DIV;
                    end
                end else if (has_next) begin
                    idx_next    = idx_p1[CNT_W-1:0];
                    prev_v_next = cur_v_reg;
                    cur_t_next  = rd_t;
                    cur_v_next  = rd_v;
                    rd_addr     = ADDR_W'(idx_p2);
                end else begin
                    cursor_next = idx_p1[CNT_W-1:0];
                    res_next    = '0;
                    status_next = STS_RANGE;
                    state_next  = S_DONE;
                end
            end
            S_MUL: begin
                // quotient fits 33 bits since the offset never exceeds the span
                rem_next   = {1'b0, prod[63:DIV_STEPS]};
                low_next   = prod[DIV_STEPS-1:0];
                step_next  = '0;
                state_next = S_DIV;
            end
            S_DIV: begin
                rem_next  = ge ? trial_sub[31:0] : trial[31:0];
                low_next  = {low_reg[DIV_STEPS-2:0], ge};
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(DIV_STEPS - 1)) begin
                    state_next = S_DONE;
                    status_next = STS_OK;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    if (status_reg != STS_OK) begin
                        m_result_next = '0;
                    end else begin
                        m_result_next = res_reg;
                    end
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // res holds on the last divider step; the quotient is written to res while div_done_reg is set
        if (state_reg == S_DIV && step_reg == STEP_W'(DIV_STEPS - 1)) begin
            res_next = res_reg;
        end
    end

    // quotient to result, taken on the first cycle of S_DONE after a division
    logic div_done_reg;
    logic signed [VALUE_W-1:0] div_res;
    assign div_res = (op_reg == OP_LINEAR) ? sat32(lin_sum) : sat32(quot_s);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            cursor_reg   <= '0;
            m_valid_reg  <= 1'b0;
            div_done_reg <= 1'b0;
        end else begin
            state_reg    <= (div_done_reg) ? S_DONE : state_next;
            count_reg    <= count_next;
            cursor_reg   <= cursor_next;
            m_valid_reg  <= div_done_reg ? m_valid_reg && !m_ready : m_valid_next;
            div_done_reg <= (state_reg == S_DIV) && (step_reg == STEP_W'(DIV_STEPS - 1));
        end
    end

    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        qtime_reg    <= qtime_next;
        idx_reg      <= idx_next;
        prev_t_reg   <= prev_t_next;
        prev_v_reg   <= prev_v_next;
        cur_t_reg    <= cur_t_next;
        cur_v_reg    <= cur_v_next;
        neg_reg      <= neg_next;
        mag_reg      <= mag_next;
        a_reg        <= a_next;
        dt_reg       <= dt_next;
        rem_reg      <= rem_next;
        low_reg      <= low_next;
        step_reg     <= step_next;
        status_reg   <= status_next;
        m_status_reg <= div_done_reg ? m_status_reg : m_status_next;
        m_result_reg <= div_done_reg ? m_result_reg : m_result_next;
        res_reg      <= div_done_reg ? div_res : res_next;
    end

endmodule

### sv/tti_chk.sv
`timescale 1ns / 1ps
// Port-level checker for the time table interpolator, bound to the top level.
module tti_chk (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               cfg_wr_en,
    input logic [tti_pkg::CNT_W-1:0]          cfg_wr_data,
    input logic                               s_valid,
    input logic                               s_ready,
    input logic [1:0]                         s_opcode,
    input logic [tti_pkg::INDEX_W-1:0]        s_entry_index,
    input logic [tti_pkg::TIME_W-1:0]         s_entry_time,
    input logic signed [tti_pkg::VALUE_W-1:0] s_entry_value,
    input logic [tti_pkg::TIME_W-1:0]         s_query_time,
    input logic                               m_valid,
    input logic                               m_ready,
    input logic signed [tti_pkg::VALUE_W-1:0] m_result_value,
    input logic [tti_pkg::STATUS_W-1:0]       m_status
);
    import tti_pkg::*;

    // a stalled result item holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result_value) && $stable(m_status))
        else $error("result item changed while stalled");

    // any non-ok status carries a zero value
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != STS_OK |-> m_result_value == '0)
        else $error("non-zero value with error status");

    // a query keeps the input closed for at least the next cycle
    a_query_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_opcode != OP_LOAD |=> !s_ready)
        else $error("input open straight after a query");

    // reset empties the result register
    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind time_table_interpolator tti_chk u_tti_chk (.*);

### tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the time table interpolator with randomised flow control.
module testbench;
    import tti_pkg::*;

    localparam int WATCHDOG_LIMIT = 6000;
    localparam int SETTLE_CYCLES  = 64;
    localparam int RANDOM_ITEMS   = 900;
    localparam int LONG_HOLD      = 400;
    localparam int MAX_PRINTED    = 100;

    localparam logic signed [VALUE_W-1:0] VAL_MIN  = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] VAL_MAX  = 32'sh7FFF_FFFF;
    localparam logic [TIME_W-1:0]         TIME_MAX = 32'hFFFF_FFFF;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [STATUS_W-1:0]       status;
    } interp_result_t;

    class interp_scoreboard;
        logic [TIME_W-1:0]         point_time  [TABLE_DEPTH];
        logic signed [VALUE_W-1:0] point_value [TABLE_DEPTH];
        int unsigned               n_points;
        int unsigned               cursor;
        interp_result_t            awaited[$];
        int                        errors;
        int                        loads;
        int                        queries;
        int                        status_seen [5];

        function new();
            n_points = 0;
            cursor   = 0;
            errors   = 0;
            loads    = 0;
            queries  = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        function void set_count(logic [CNT_W-1:0] cnt);
            n_points = cnt;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function longint clamp32(longint v);
            if (v > longint'(VAL_MAX)) return longint'(VAL_MAX);
            if (v < longint'(VAL_MIN)) return longint'(VAL_MIN);
            return v;
        endfunction

        // d * a / span truncated toward zero, split so nothing overflows (a <= span)
        function longint part_of_step(longint d, longint unsigned a, longint unsigned span);
            bit                neg;
            longint unsigned   mag;
            longint unsigned   qd;
            longint unsigned   rd;
            longint unsigned   q;
            neg = d < 0;
            mag = neg ? longint'(-d) : d;
            qd  = mag / span;
            rd  = mag % span;
            q   = a * qd + (a * rd) / span;
            return neg ? -longint'(q) : longint'(q);
        endfunction

        function void note_item(opcode_t op, logic [INDEX_W-1:0] idx, logic [TIME_W-1:0] et,
                                logic signed [VALUE_W-1:0] ev, logic [TIME_W-1:0] qt);
            int unsigned       n;
            int unsigned       c;
            bit                hit;
            bit                more;
            longint unsigned   t0;
            longint unsigned   t1;
            longint unsigned   tq;
            longint unsigned   q;
            longint            v0;
            longint            v1;
            longint            d;
            longint            res;
            logic [STATUS_W-1:0] st;
            interp_result_t    r;

            if (op == OP_LOAD) begin
                point_time[idx]  = et;
                point_value[idx] = ev;
                loads++;
                return;
            end

            queries++;
            tq  = qt;
            n   = (n_points > TABLE_DEPTH) ? TABLE_DEPTH : n_points;
            res = 0;
            st  = STS_RANGE;
            hit = 0;

            if (n == 0) begin
                st = STS_EMPTY;
            end else if (point_time[0] > qt) begin
                st = STS_BEFORE;
            end else begin
                c = cursor;
                if (c >= n) c = 0;
                else if (op == OP_LINEAR && point_time[c] > qt) c = 0;
                else if (op != OP_LINEAR && c > 0 && point_time[c-1] > qt) c = 0;

                while (c < n && !hit) begin
                    more = (c + 1) < n;
                    t0   = point_time[c];
                    t1   = more ? point_time[c+1] : 0;
                    v0   = point_value[c];
                    v1   = more ? point_value[c+1] : 0;
                    case (op)
                        OP_LINEAR: begin
                            if (t0 == tq) begin
                                res = v0;
                                st  = STS_OK;
                                hit = 1;
                            end else if (more && t0 <= tq && t1 >= tq) begin
                                hit = 1;
                                if (t1 <= t0) begin
                                    st = STS_ZERO;
                                end else begin
                                    res = v0 + part_of_step(v1 - v0, tq - t0, t1 - t0);
                                    st  = STS_OK;
                                end
                            end
                        end
                        OP_HOLD: begin
                            if (t0 == tq) begin
                                res = v0;
                                st  = STS_OK;
                                hit = 1;
                            end else if (c > 0 && tq < t0) begin
                                res = point_value[c-1];
                                st  = STS_OK;
                                hit = 1;
                            end
                        end
                        default: begin
                            // last segment also matches at its end time
                            if (more && ((t0 <= tq && t1 > tq) || (c + 2 == n && t1 == tq))) begin
                                hit = 1;
                                if (t1 <= t0) begin
                                    st = STS_ZERO;
                                end else begin
                                    d   = v1 - v0;
                                    q   = (d < 0 ? longint'(-d) : d) / (t1 - t0);
                                    res = clamp32(d < 0 ? -longint'(q) : longint'(q));
                                    st  = STS_OK;
                                end
                            end
                        end
                    endcase
                    if (!hit) c++;
                end
                cursor = c & 11'h7FF;
                if (!hit) st = STS_RANGE;
            end

            if (st != STS_OK) res = 0;
            r.value  = clamp32(res);
            r.status = st;
            awaited.push_back(r);
        endfunction

        task report_mismatch(string what);
            errors++;
            if (errors <= MAX_PRINTED) $display("MISMATCH at %0t: %s", $realtime, what);
        endtask

        task check_result(logic signed [VALUE_W-1:0] value, logic [STATUS_W-1:0] status);
            interp_result_t want;
            if (awaited.size() == 0) begin
                report_mismatch($sformatf("result with nothing awaited: value %0d status %0d",
                                          value, status));
            end else begin
                want = awaited.pop_front();
                if (want.status < 5) status_seen[want.status]++;
                if (status !== want.status)
                    report_mismatch($sformatf("status %0d, predicted %0d", status, want.status));
                if (value !== want.value)
                    report_mismatch($sformatf("result_value %0d, predicted %0d",
                                              value, want.value));
            end
        endtask
    endclass

    logic                       aclk          = 1'b0;
    logic                       aresetn       = 1'b0;
    logic                       cfg_wr_en     = 1'b0;
    logic [CNT_W-1:0]           cfg_wr_data   = '0;
    logic                       s_valid       = 1'b0;
    logic                       s_ready;
    logic [1:0]                 s_opcode      = OP_LOAD;
    logic [INDEX_W-1:0]         s_entry_index = '0;
    logic [TIME_W-1:0]          s_entry_time  = '0;
    logic signed [VALUE_W-1:0]  s_entry_value = '0;
    logic [TIME_W-1:0]          s_query_time  = '0;
    logic                       m_valid;
    logic                       m_ready       = 1'b0;
    logic signed [VALUE_W-1:0]  m_result_value;
    logic [STATUS_W-1:0]        m_status;

    interp_scoreboard sb = new();

    int  burst_left   = 0;
    bit  steady       = 0;
    int  items_done   = 0;
    int  settings     = 0;
    bit  hold_req     = 0;
    int  hold_left    = 0;
    int  ready_mode   = 0;
    int  rx_cycle     = 0;
    int  idle_cycles  = 0;

    always #5 aclk = ~aclk;

    time_table_interpolator dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_opcode       (s_opcode),
        .s_entry_index  (s_entry_index),
        .s_entry_time   (s_entry_time),
        .s_entry_value  (s_entry_value),
        .s_query_time   (s_query_time),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_value (m_result_value),
        .m_status       (m_status)
    );

    // Result side: check on handshake, stall on a shifting pattern, long hold on request
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_result_value, m_status);
        rx_cycle++;
        if (rx_cycle % 50 == 0) ready_mode = $urandom_range(0, 3);
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (hold_req) begin
            hold_req  = 0;
            hold_left = LONG_HOLD;
            m_ready <= 1'b0;
        end else begin
            case (ready_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= ($urandom_range(0, 3) != 0);
                2: m_ready <= ($urandom_range(0, 9) < 3);
                default: m_ready <= ((rx_cycle / 7) % 2 == 0);
            endcase
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic send_item(opcode_t op, logic [INDEX_W-1:0] idx, logic [TIME_W-1:0] et,
                             logic signed [VALUE_W-1:0] ev, logic [TIME_W-1:0] qt);
        int gap;
        if (!steady && burst_left == 0) begin
            case ($urandom_range(0, 7))
                0:       gap = $urandom_range(20, 60);
                1, 2:    gap = 0;
                default: gap = $urandom_range(1, 6);
            endcase
            burst_left = $urandom_range(1, 12);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        if (burst_left > 0) burst_left--;
        s_valid       <= 1'b1;
        s_opcode      <= op;
        s_entry_index <= idx;
        s_entry_time  <= et;
        s_entry_value <= ev;
        s_query_time  <= qt;
        do @(posedge aclk); while (!s_ready);
        sb.note_item(op, idx, et, ev, qt);
    endtask

    task automatic send_load(logic [INDEX_W-1:0] idx, logic [TIME_W-1:0] t,
                             logic signed [VALUE_W-1:0] v);
        send_item(OP_LOAD, idx, t, v, $urandom);
    endtask

    // unused load fields carry junk on queries
    task automatic send_query(opcode_t op, logic [TIME_W-1:0] qt);
        send_item(op, INDEX_W'($urandom), $urandom, $urandom, qt);
    endtask

    // drop valid and wait until every result is back and the block has gone quiet
    task automatic settle();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_count(logic [CNT_W-1:0] cnt);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= cnt;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.set_count(cnt);
        settings++;
    endtask

    function automatic logic signed [VALUE_W-1:0] rand_value(int mode);
        case (mode)
            0: return $urandom;
            1: return $signed($urandom_range(0, 2000)) - 1000;
            default: begin
                case ($urandom_range(0, 4))
                    0:       return VAL_MIN;
                    1:       return VAL_MAX;
                    2:       return 0;
                    3:       return -1;
                    default: return $urandom;
                endcase
            end
        endcase
    endfunction

    function automatic logic [TIME_W-1:0] pick_query_time(int n, int k);
        logic [TIME_W-1:0] tk;
        logic [TIME_W-1:0] tn;
        if (n == 0) return $urandom;
        tk = sb.point_time[k];
        tn = (k + 1 < n) ? sb.point_time[k+1] : tk;
        case ($urandom_range(0, 9))
            0, 1, 2: return tk;
            3, 4, 5: return (tn > tk) ? tk + ($urandom % (tn - tk)) : tk;
            6:       return tk - 1;
            7:       return sb.point_time[0] - $urandom_range(1, 4);
            8:       return sb.point_time[n-1] + $urandom_range(1, 4);
            default: return $urandom;
        endcase
    endfunction

    task automatic load_table(int n, int time_mode, int value_mode, bit dup);
        longint unsigned t;
        longint unsigned max_gap;
        case (time_mode)
            0:       max_gap = 8;
            1:       max_gap = 100000;
            default: max_gap = (64'hFFFF_FFFF - 1000) / n;
        endcase
        if (time_mode == 2) t = $urandom_range(0, 1000);
        else t = $urandom_range(0, 32'(64'hFFFF_FFFF - n * max_gap));
        for (int i = 0; i < n; i++) begin
            send_load(INDEX_W'(i), t[TIME_W-1:0], rand_value(value_mode));
            if (!(dup && $urandom_range(0, 7) == 0)) t += $urandom_range(1, 32'(max_gap));
        end
    endtask

    task automatic run_phase(int phase_no);
        int  n;
        int  budget;
        int  k;
        int  sweep_k;
        bit  sweep;
        case ($urandom_range(0, 19))
            0:           n = 0;
            1:           n = $urandom_range(65, 200);
            2, 3, 4, 5:  n = $urandom_range(13, 64);
            default:     n = $urandom_range(1, 12);
        endcase
        settle();
        write_count(CNT_W'(n));
        steady  = ($urandom_range(0, 3) == 0);
        sweep   = ($urandom_range(0, 4) < 2);
        sweep_k = 0;
        if (n > 0) load_table(n, $urandom_range(0, 2), $urandom_range(0, 2),
                              $urandom_range(0, 3) == 0);
        items_done += n;
        // fill the block while the result side holds off
        if (phase_no == 2 || phase_no == 9) hold_req = 1;
        budget = $urandom_range(25, 60);
        for (int i = 0; i < budget; i++) begin
            case ($urandom_range(0, 19))
                0: send_load(INDEX_W'($urandom), $urandom, rand_value(0));
                1: if (n > 0) send_load(INDEX_W'($urandom_range(0, n - 1)), $urandom,
                                        rand_value(2));
                   else send_query(OP_HOLD, $urandom);
                default: begin
                    if (n == 0) k = 0;
                    else if (sweep) begin
                        k       = sweep_k;
                        sweep_k = (sweep_k + $urandom_range(0, 1)) % n;
                    end else k = $urandom_range(0, n - 1);
                    send_query(opcode_t'($urandom_range(1, 3)), pick_query_time(n, k));
                end
            endcase
        end
        items_done += budget;
    endtask

    initial begin
        int phase_no;
        int k;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty table
        write_count(0);
        send_query(OP_LINEAR, 0);
        send_query(OP_HOLD, TIME_MAX);
        send_query(OP_SLOPE, $urandom);
        settle();

        // small hand-built table: extreme values, equal end times
        write_count(6);
        send_load(0, 10, VAL_MIN);
        send_load(1, 11, VAL_MAX);
        send_load(2, 12, VAL_MIN);
        send_load(3, 32'h8000_0000, 32'sh0001_0000);
        send_load(4, TIME_MAX, -5);
        send_load(5, TIME_MAX, 7);
        send_query(OP_LINEAR, 0);               // before first point
        send_query(OP_LINEAR, 10);              // exact hit
        send_query(OP_SLOPE, 10);               // slope saturates high
        send_query(OP_SLOPE, 11);               // slope saturates low
        send_query(OP_LINEAR, 1000);            // interpolated
        send_query(OP_HOLD, 1000);
        send_query(OP_LINEAR, 32'h8000_0000);
        send_query(OP_SLOPE, TIME_MAX);         // zero-length last segment
        send_query(OP_LINEAR, TIME_MAX);
        send_query(OP_HOLD, 32'h7FFF_FFFF);     // cursor restarts
        send_query(OP_LINEAR, 12);
        send_query(OP_HOLD, 5);
        settle();

        // one point: no segment, out of range past it
        write_count(1);
        send_query(OP_SLOPE, 10);
        send_query(OP_LINEAR, 20);
        send_query(OP_HOLD, 20);
        send_query(OP_HOLD, 10);

        phase_no = 0;
        while (items_done < RANDOM_ITEMS) begin
            run_phase(phase_no);
            phase_no++;
        end

        // full depth, then a count above the depth
        settle();
        write_count(CNT_W'(TABLE_DEPTH));
        steady = 1;
        for (int i = 0; i < TABLE_DEPTH; i++)
            send_load(INDEX_W'(i), 32'(i * 4000000 + $urandom_range(0, 3999999)),
                      rand_value(0));
        steady = 0;
        for (int pass = 0; pass < 2; pass++) begin
            for (int i = 0; i < 15; i++) begin
                k = $urandom_range(0, TABLE_DEPTH - 1);
                send_query(opcode_t'($urandom_range(1, 3)), pick_query_time(TABLE_DEPTH, k));
            end
            settle();
            if (pass == 0) write_count(11'h7FF);
        end

        settle();
        $display("Covered %0d loads and %0d queries over %0d count settings, empty to full depth.",
                 sb.loads, sb.queries, settings);
        $display("Statuses ok/empty/before/out-of-range/zero-segment: %0d/%0d/%0d/%0d/%0d",
                 sb.status_seen[0], sb.status_seen[1], sb.status_seen[2],
                 sb.status_seen[3], sb.status_seen[4]);
        if (sb.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

### sim.f
sv/tti_pkg.sv
sv/time_table_interpolator.sv
sv/tti_chk.sv
tb/testbench.sv
